// File: rtl/m4rt_pkg.sv
// Shared types and field layout for the 4x4 row transform.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps

package m4rt_pkg;

	localparam int unsigned ElemW  = 32;
	localparam int unsigned ProdW  = 2 * ElemW;
	localparam int unsigned PairW  = ProdW + 1;
	localparam int unsigned SumW   = ProdW + 2;
	localparam int unsigned RowW   = 2;
	localparam int unsigned Dim    = 4;
	localparam int unsigned TdataW = 136;

	typedef enum logic {
		ACT_LOAD     = 1'b0,
		ACT_MULTIPLY = 1'b1
	} action_t;

	typedef logic [ElemW-1:0]           elem_t;
	typedef elem_t [Dim-1:0]            row_t;
	typedef row_t [Dim-1:0]             matrix_t;
	typedef logic [SumW-1:0]            sum_t;
	typedef sum_t [Dim-1:0]             sums_t;

	typedef struct packed {
		logic adv1;
		logic adv2;
		logic adv3;
	} pipe_ctl_t;

	localparam elem_t SatMax = {1'b0, {(ElemW-1){1'b1}}};
	localparam elem_t SatMin = {1'b1, {(ElemW-1){1'b0}}};

endpackage

// File: rtl/matrix4_row_transform.sv
// A multiply word goes through product, pair-sum, total and output registers to m_axis.
// One word per cycle unless m_axis stalls; four column lanes of four 32x32 multipliers.
// A load word writes its store row at the accepting edge and gives no output.
// Reset clears the pipeline valid flags and zeroes the stored matrix.
// Depends on m4rt_pkg, m4rt_store, m4rt_lane, m4rt_merge.
`timescale 1ns / 1ps

module matrix4_row_transform #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// row_index [1:0], elem0 [33:2], elem1 [65:34], elem2 [97:66], elem3 [129:98], zero fill
	input  logic [135:0] s_axis_tdata,
	// action [0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_row [1:0], prod0 [33:2], prod1 [65:34], prod2 [97:66], prod3 [129:98], zero fill
	output logic [135:0] m_axis_tdata,
	// saturated [0]
	output logic         m_axis_tuser
);

	logic                      acc;
	logic                      acc_load;
	logic                      acc_mul;
	logic [m4rt_pkg::RowW-1:0] in_row;
	m4rt_pkg::row_t            in_elems;
	m4rt_pkg::matrix_t         matrix;
	m4rt_pkg::pipe_ctl_t       ctl;
	m4rt_pkg::sums_t           sums;
	logic                      adv4;
	logic                      v1_q, v2_q, v3_q;
	logic [m4rt_pkg::RowW-1:0] row_s1, row_s2, row_s3;

	assign in_row   = s_axis_tdata[m4rt_pkg::RowW-1:0];
	assign in_elems = s_axis_tdata[m4rt_pkg::RowW + m4rt_pkg::Dim * m4rt_pkg::ElemW - 1:m4rt_pkg::RowW];

	assign adv4     = !m_axis_tvalid || m_axis_tready;
	assign ctl.adv3 = !v3_q || adv4;
	assign ctl.adv2 = !v2_q || ctl.adv3;
	assign ctl.adv1 = !v1_q || ctl.adv2;

	assign s_axis_tready = ctl.adv1;
	assign acc      = s_axis_tvalid && s_axis_tready;
	assign acc_load = acc && (m4rt_pkg::action_t'(s_axis_tuser) == m4rt_pkg::ACT_LOAD);
	assign acc_mul  = acc && (m4rt_pkg::action_t'(s_axis_tuser) == m4rt_pkg::ACT_MULTIPLY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (ctl.adv1) v1_q <= acc_mul;
			if (ctl.adv2) v2_q <= v1_q;
			if (ctl.adv3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv1) row_s1 <= in_row;
		if (ctl.adv2) row_s2 <= row_s1;
		if (ctl.adv3) row_s3 <= row_s2;
	end

	m4rt_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (acc_load),
		.wr_row  (in_row),
		.wr_data (in_elems),
		.matrix  (matrix)
	);

	for (genvar c = 0; c < m4rt_pkg::Dim; c++) begin : g_lane
		m4rt_pkg::row_t col;
		for (genvar k = 0; k < m4rt_pkg::Dim; k++) begin : g_col
			assign col[k] = matrix[k][c];
		end
		m4rt_lane u_lane (
			.clk (clk),
			.ctl (ctl),
			.a   (in_elems),
			.b   (col),
			.sum (sums[c])
		);
	end

	m4rt_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv4),
		.in_valid  (v3_q),
		.in_row    (row_s3),
		.sums      (sums),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_sat   (m_axis_tuser)
	);

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(v3_q))
		else $error("output raised without a finished multiply");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		acc_load |=> (matrix[$past(in_row)] == $past(in_elems)))
		else $error("store row not written by load word");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
			(m_axis_tdata[33:2] == m4rt_pkg::SatMax || m_axis_tdata[33:2] == m4rt_pkg::SatMin
			|| m_axis_tdata[65:34] == m4rt_pkg::SatMax || m_axis_tdata[65:34] == m4rt_pkg::SatMin
			|| m_axis_tdata[97:66] == m4rt_pkg::SatMax || m_axis_tdata[97:66] == m4rt_pkg::SatMin
			|| m_axis_tdata[129:98] == m4rt_pkg::SatMax
			|| m_axis_tdata[129:98] == m4rt_pkg::SatMin))
		else $error("saturated flag without a clipped column");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && !ctl.adv3) |=> (v3_q && $stable(row_s3)))
		else $error("stalled stage lost its word");

endmodule

// File: rtl/m4rt_store.sv
// Right-hand matrix store: 16 words, cleared at reset, written a row at a time.
// Depends on m4rt_pkg.
`timescale 1ns / 1ps

module m4rt_store (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [m4rt_pkg::RowW-1:0] wr_row,
	input  m4rt_pkg::row_t          wr_data,
	output m4rt_pkg::matrix_t       matrix
);

	m4rt_pkg::matrix_t mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (wr_en) begin
			mat_q[wr_row] <= wr_data;
		end
	end

	assign matrix = mat_q;

endmodule

// File: rtl/m4rt_lane.sv
// One column lane: four signed products, pair sums, then the exact 66-bit total.
// Depends on m4rt_pkg.
`timescale 1ns / 1ps

module m4rt_lane (
	input  logic                clk,
	input  m4rt_pkg::pipe_ctl_t ctl,
	input  m4rt_pkg::row_t      a,
	input  m4rt_pkg::row_t      b,
	output m4rt_pkg::sum_t      sum
);

	logic [m4rt_pkg::Dim-1:0][m4rt_pkg::ProdW-1:0] prod_s1;
	logic [1:0][m4rt_pkg::PairW-1:0]               pair_s2;
	m4rt_pkg::sum_t                                sum_s3;

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			for (int k = 0; k < m4rt_pkg::Dim; k++) begin
				prod_s1[k] <= $signed(a[k]) * $signed(b[k]);
			end
		end
		if (ctl.adv2) begin
			for (int j = 0; j < 2; j++) begin
				pair_s2[j] <= $signed({prod_s1[2*j][m4rt_pkg::ProdW-1], prod_s1[2*j]})
					+ $signed({prod_s1[2*j+1][m4rt_pkg::ProdW-1], prod_s1[2*j+1]});
			end
		end
		if (ctl.adv3) begin
			sum_s3 <= $signed({pair_s2[0][m4rt_pkg::PairW-1], pair_s2[0]})
				+ $signed({pair_s2[1][m4rt_pkg::PairW-1], pair_s2[1]});
		end
	end

	assign sum = sum_s3;

endmodule

// File: rtl/m4rt_merge.sv
// Merge stage: shift and saturate the lane totals, pack the output word.
// Depends on m4rt_pkg; holds the output register.
`timescale 1ns / 1ps

module m4rt_merge #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic                      in_valid,
	input  logic [m4rt_pkg::RowW-1:0] in_row,
	input  m4rt_pkg::sums_t           sums,
	output logic                      out_valid,
	output logic [m4rt_pkg::TdataW-1:0] out_data,
	output logic                      out_sat
);

	logic [m4rt_pkg::SumW-1:0]   shifted [m4rt_pkg::Dim];
	m4rt_pkg::row_t              clip;
	logic [m4rt_pkg::Dim-1:0]    lane_sat;
	logic                        valid_q;
	logic [m4rt_pkg::TdataW-1:0] data_q;
	logic                        sat_q;

	always_comb begin
		for (int c = 0; c < m4rt_pkg::Dim; c++) begin
			shifted[c] = $signed(sums[c]) >>> FRAC_BITS;
			if (!shifted[c][m4rt_pkg::SumW-1]
				&& (|shifted[c][m4rt_pkg::SumW-2:m4rt_pkg::ElemW-1])) begin
				clip[c]     = m4rt_pkg::SatMax;
				lane_sat[c] = 1'b1;
			end else if (shifted[c][m4rt_pkg::SumW-1]
				&& !(&shifted[c][m4rt_pkg::SumW-2:m4rt_pkg::ElemW-1])) begin
				clip[c]     = m4rt_pkg::SatMin;
				lane_sat[c] = 1'b1;
			end else begin
				clip[c]     = shifted[c][m4rt_pkg::ElemW-1:0];
				lane_sat[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {{(m4rt_pkg::TdataW - m4rt_pkg::RowW - m4rt_pkg::Dim * m4rt_pkg::ElemW){1'b0}},
				clip, in_row};
			sat_q  <= |lane_sat;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_sat   = sat_q;

endmodule

// File: tb/sv/matrix4_product_check.sv
// Checker for matrix4_row_transform: tracks the stored right-hand matrix from
// accepted load words, predicts each product row and compares m_axis words in order.
// Depends on m4rt_pkg.
`timescale 1ns / 1ps

module matrix4_product_check
	import m4rt_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	// row_index [1:0], elem0 [33:2], elem1 [65:34], elem2 [97:66], elem3 [129:98], zero fill
	input  logic [135:0] s_axis_tdata,
	// action [0]
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_row [1:0], prod0 [33:2], prod1 [65:34], prod2 [97:66], prod3 [129:98], zero fill
	input  logic [135:0] m_axis_tdata,
	// saturated [0]
	input  logic         m_axis_tuser,
	output int           errors,
	output int           pending
);

	typedef struct packed {
		logic [RowW-1:0] tag;
		row_t            prods;
		logic            saturated;
	} product_row_t;

	localparam logic signed [SumW-1:0] ColMax = 66'sd2147483647;
	localparam logic signed [SumW-1:0] ColMin = -66'sd2147483648;

	matrix_t      right_rows;
	product_row_t expected_rows[$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report(input string msg);
		if (errors < 40) begin
			$display("%0t: %s", $time, msg);
		end
		errors++;
	endtask

	function automatic product_row_t predict_row(input logic [RowW-1:0] tag, input row_t left);
		product_row_t            res;
		logic signed [SumW-1:0]  acc;
		logic signed [SumW-1:0]  shifted;
		logic signed [ProdW-1:0] term;
		int                      c;
		int                      k;
		res.tag       = tag;
		res.prods     = '0;
		res.saturated = 1'b0;
		for (c = 0; c < Dim; c++) begin
			acc = '0;
			for (k = 0; k < Dim; k++) begin
				term = $signed(left[k]) * $signed(right_rows[k][c]);
				acc  = acc + term;
			end
			shifted = acc >>> FRAC_BITS;
			if (shifted > ColMax) begin
				res.prods[c]  = SatMax;
				res.saturated = 1'b1;
			end else if (shifted < ColMin) begin
				res.prods[c]  = SatMin;
				res.saturated = 1'b1;
			end else begin
				res.prods[c] = shifted[ElemW-1:0];
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		product_row_t want;
		product_row_t got;
		int           c;
		if (!arst_n) begin
			right_rows = '0;
			expected_rows.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (action_t'(s_axis_tuser) == ACT_LOAD) begin
					right_rows[s_axis_tdata[1:0]] = s_axis_tdata[129:2];
				end else begin
					expected_rows.push_back(predict_row(s_axis_tdata[1:0], s_axis_tdata[129:2]));
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.tag       = m_axis_tdata[1:0];
				got.prods     = m_axis_tdata[129:2];
				got.saturated = m_axis_tuser;
				if (expected_rows.size() == 0) begin
					report($sformatf("m_axis word with no product row pending: %h", m_axis_tdata));
				end else begin
					want = expected_rows.pop_front();
					if (got.tag !== want.tag) begin
						report($sformatf("out_row: got %0d, expected %0d", got.tag, want.tag));
					end
					for (c = 0; c < Dim; c++) begin
						if (got.prods[c] !== want.prods[c]) begin
							report($sformatf("row %0d prod%0d: got %h, expected %h",
								want.tag, c, got.prods[c], want.prods[c]));
						end
					end
					if (got.saturated !== want.saturated) begin
						report($sformatf("row %0d saturated: got %b, expected %b",
							want.tag, got.saturated, want.saturated));
					end
				end
			end
		end
		pending = expected_rows.size();
	end

endmodule

// File: tb/sv/tb_matrix4_row_transform.sv
// Testbench top for matrix4_row_transform: drives load and multiply words in bursts,
// stalls the output side, and reports the verdict from matrix4_product_check.
// Depends on m4rt_pkg, matrix4_product_check and the rtl under test.
`timescale 1ns / 1ps

module tb_matrix4_row_transform;
	import m4rt_pkg::*;

	localparam int    RandomWords   = 1200;
	localparam int    WatchdogLimit = 4000;
	localparam elem_t OneQ          = 32'h0001_0000;
	localparam elem_t HalfQ         = 32'h0000_8000;
	localparam elem_t NegOne        = 32'hFFFF_FFFF;
	localparam elem_t Lsb           = 32'h0000_0001;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata  = '0;
	logic         s_axis_tuser  = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [135:0] m_axis_tdata;
	logic         m_axis_tuser;

	int check_errors;
	int check_pending;
	int words_sent  = 0;
	int burst_left  = 0;
	int idle_cycles = 0;

	matrix4_row_transform dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	matrix4_product_check product_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (check_errors),
		.pending       (check_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic elem_t rand_elem();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 11))
			0: begin
				return SatMax;
			end
			1: begin
				return SatMin;
			end
			2: begin
				return '0;
			end
			3: begin
				return NegOne;
			end
			4, 5, 6: begin
				return r;
			end
			7, 8: begin
				return {{8{r[23]}}, r[23:0]};
			end
			default: begin
				return {{14{r[17]}}, r[17:0]};
			end
		endcase
	endfunction

	function automatic row_t rand_row();
		return {rand_elem(), rand_elem(), rand_elem(), rand_elem()};
	endfunction

	// elems is {elem3, elem2, elem1, elem0}
	task automatic send_word(input action_t act, input logic [RowW-1:0] tag, input row_t elems);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, elems, tag};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	initial begin : stimulus
		row_t elems;
		int   r;
		int   n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(ACT_MULTIPLY, 2'd1, {SatMin, SatMax, NegOne, OneQ});
		for (r = 0; r < Dim; r++) begin
			elems    = '0;
			elems[r] = OneQ;
			send_word(ACT_LOAD, r[1:0], elems);
		end
		send_word(ACT_MULTIPLY, 2'd2, {NegOne, 32'h0, SatMin, SatMax});
		send_word(ACT_LOAD, 2'd0, {HalfQ, OneQ, NegOne, Lsb});
		send_word(ACT_MULTIPLY, 2'd0, {32'h0, 32'h0, 32'h0, NegOne});
		send_word(ACT_MULTIPLY, 2'd3, {32'h0, 32'h0, 32'h0, Lsb});
		for (r = 0; r < Dim; r++) begin
			send_word(ACT_LOAD, r[1:0], {4{SatMax}});
		end
		send_word(ACT_MULTIPLY, 2'd1, {4{SatMax}});
		send_word(ACT_MULTIPLY, 2'd2, {4{SatMin}});
		send_word(ACT_MULTIPLY, 2'd3, {32'h0, 32'h0, 32'h0, OneQ});
		for (r = 0; r < Dim; r++) begin
			send_word(ACT_LOAD, r[1:0], {4{SatMin}});
		end
		send_word(ACT_MULTIPLY, 2'd0, {4{SatMin}});
		send_word(ACT_MULTIPLY, 2'd3, {4{NegOne}});

		n = 0;
		while (n < RandomWords) begin
			if ($urandom_range(0, 15) == 0) begin
				for (r = 0; r < Dim; r++) begin
					send_word(ACT_LOAD, r[1:0], rand_row());
				end
				n += Dim;
			end else begin
				send_word(($urandom_range(0, 4) == 0) ? ACT_LOAD : ACT_MULTIPLY,
					2'($urandom_range(0, 3)), rand_row());
				n++;
			end
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (check_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (check_errors == 0 && check_pending == 0) begin
			$display("tb_matrix4_row_transform: clean");
		end else begin
			$display("tb_matrix4_row_transform: errors");
		end
		$finish;
	end

	initial begin : receiver
		bit long_hold_done;
		int mode;
		int stretch;
		forever begin
			if (!long_hold_done && words_sent >= 300) begin
				@(posedge clk) m_axis_tready <= 1'b0;
				repeat (250) @(posedge clk);
				long_hold_done = 1'b1;
			end
			mode    = $urandom_range(0, 3);
			stretch = $urandom_range(10, 60);
			repeat (stretch) begin
				@(posedge clk);
				case (mode)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= ($urandom_range(0, 3) != 0);
					end
					2: begin
						m_axis_tready <= 1'($urandom_range(0, 1));
					end
					default: begin
						m_axis_tready <= ($urandom_range(0, 4) == 0);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WatchdogLimit) begin
			$display("tb_matrix4_row_transform: errors");
			$finish;
		end
	end

endmodule
